[rtl/ahd_pkg.sv]
`timescale 1ns / 1ps
// ahd_pkg: shared types and constants of the attack/hold/decay envelope core
// used by ahd_iter_unit and attack_hold_decay_envelope_core; no dependencies

package ahd_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_BAR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_VALUE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING_VALUE = 3'd5;

	// register reset values
	localparam logic [15:0] TICKS_PER_BAR_RST = 16'd384;
	localparam logic [15:0] CEILING_RST       = 16'hFFFF;

	// stage length steps
	localparam int STEP_W       = 4;
	localparam int MAX_STEP_DEF = 8;

	// input word kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_FIRE = 1'b1;

	// level is unsigned q16, full scale is 1.0
	localparam int          LEVEL_W    = 17;
	localparam logic [16:0] FULL_SCALE = 17'h10000;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_ATTACK = 2'd1,
		PH_HOLD   = 2'd2,
		PH_DECAY  = 2'd3
	} phase_t;

	// increment = (2^20 >> step) / ticks_per_bar
	localparam int          DIV_NUM_W = 21;
	localparam logic [20:0] DIV_NUM   = 21'h100000;

	// iteration counts of the shared unit
	localparam int         CNT_W     = 5;
	localparam logic [4:0] DIV_STEPS = 5'd21;
	localparam logic [4:0] MUL_STEPS = 5'd17;

	// command to the shared unit
	typedef struct packed {
		logic                 start;
		logic                 op_mul;
		logic [DIV_NUM_W-1:0] a;
		logic [15:0]          b;
	} unit_cmd_t;

	// status of the shared unit
	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quo;
		logic [15:0]          prod;
	} unit_sts_t;

endpackage

[rtl/ahd_iter_unit.sv]
`timescale 1ns / 1ps
// ahd_iter_unit: one shared adder stepped as a restoring divider or a shift-add multiplier
// depends on ahd_pkg

module ahd_iter_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  ahd_pkg::unit_cmd_t cmd,
	output ahd_pkg::unit_sts_t sts
);

	logic                      busy_q;
	logic                      done_q;
	logic                      mul_q;
	logic [ahd_pkg::CNT_W-1:0] cnt_q;
	logic [16:0]               hi_q;
	logic [ahd_pkg::DIV_NUM_W-1:0] lo_q;
	logic [15:0]               opb_q;

	logic [16:0] shifted;
	logic [17:0] add_a;
	logic [17:0] add_b;
	logic        add_cin;
	logic [17:0] add_sum;
	logic        load;

	assign load = cmd.start && !busy_q;

	// shared adder: add multiplicand or subtract divisor
	always_comb begin
		shifted = {hi_q[15:0], lo_q[ahd_pkg::DIV_NUM_W-1]};
		if (mul_q) begin
			add_a   = {1'b0, hi_q};
			add_b   = lo_q[0] ? {2'b00, opb_q} : 18'd0;
			add_cin = 1'b0;
		end else begin
			add_a   = {1'b0, shifted};
			add_b   = ~{2'b00, opb_q};
			add_cin = 1'b1;
		end
		add_sum = add_a + add_b + {17'd0, add_cin};
	end

	// sequencing control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			mul_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			mul_q  <= cmd.op_mul;
			cnt_q  <= cmd.op_mul ? ahd_pkg::MUL_STEPS : ahd_pkg::DIV_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == ahd_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (load) begin
			hi_q  <= '0;
			lo_q  <= cmd.op_mul ? {4'd0, cmd.a[16:0]} : cmd.a;
			opb_q <= cmd.b;
		end else if (busy_q) begin
			if (mul_q) begin
				hi_q <= add_sum[17:1];
				lo_q <= {4'd0, add_sum[0], lo_q[16:1]};
			end else if (!add_sum[17]) begin
				hi_q <= add_sum[16:0];
				lo_q <= {lo_q[ahd_pkg::DIV_NUM_W-2:0], 1'b1};
			end else begin
				hi_q <= shifted;
				lo_q <= {lo_q[ahd_pkg::DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	// quotient, or product bits 31:16
	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.quo  = lo_q;
	assign sts.prod = {hi_q[14:0], lo_q[16]};

endmodule

[rtl/attack_hold_decay_envelope_core.sv]
`timescale 1ns / 1ps
// attack_hold_decay_envelope_core: tempo-synced attack/hold/decay envelope, top level
// depends on ahd_pkg and ahd_iter_unit
//
//  channel  | direction | handshake          | word
//  s_*      | in        | s_tvalid/s_tready  | tuser opcode, tdata finger_down
//  m_*      | out       | m_tvalid/m_tready  | tdata env_level, env_phase, shaped_value
//  cfg_*    | in        | cfg_we, no wait    | cfg_index selects register, cfg_wdata
//
// one word at a time: a tick in attack or decay runs a 21-step division for the
// increment and then a 17-step multiply for the shaped value, both on the shared
// adder; a fire, a frozen tick or a tick in idle or hold runs only the multiply.
// s_tready is high only in idle; the result waits in an output register, so the
// next word is taken while m_tvalid is still pending. asynchronous reset clears
// state, level and registers to their reset values.

module attack_hold_decay_envelope_core #(
	parameter int MAX_STEP = ahd_pkg::MAX_STEP_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input words
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [0] finger_down, [7:1] zero
	input  logic                           s_tuser,  // [0] opcode
	// result words
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [39:0]                    m_tdata,  // [16:0] env_level, [18:17] env_phase,
	                                                 // [34:19] shaped_value, [39:35] zero
	// configuration writes
	input  logic                           cfg_we,
	input  logic [ahd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ahd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_UPD  = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	localparam logic [ahd_pkg::STEP_W-1:0] STEP_MAX = ahd_pkg::STEP_W'(MAX_STEP);

	state_t state_q;

	// configuration registers
	logic                       hold_mode_q;
	logic [ahd_pkg::STEP_W-1:0] attack_step_q;
	logic [ahd_pkg::STEP_W-1:0] decay_step_q;
	logic [15:0]                ticks_per_bar_q;
	logic [15:0]                base_value_q;
	logic [15:0]                ceiling_value_q;

	// envelope state
	logic [ahd_pkg::LEVEL_W-1:0] level_q;
	ahd_pkg::phase_t             phase_q;
	logic                        finger_q;

	// shared unit command
	logic                          unit_start_q;
	logic                          unit_mul_q;
	logic [ahd_pkg::DIV_NUM_W-1:0] unit_a_q;
	logic [15:0]                   unit_b_q;
	ahd_pkg::unit_cmd_t            unit_cmd;
	ahd_pkg::unit_sts_t            unit_sts;

	// output register
	logic                        m_tvalid_q;
	logic [ahd_pkg::LEVEL_W-1:0] out_level_q;
	logic [1:0]                  out_phase_q;
	logic [15:0]                 out_shaped_q;

	logic                          accept;
	logic                          in_fire;
	logic                          in_finger;
	ahd_pkg::phase_t               ph_mid;
	logic [ahd_pkg::STEP_W-1:0]    step_sel;
	logic [ahd_pkg::STEP_W-1:0]    step_clamped;
	logic [ahd_pkg::DIV_NUM_W-1:0] div_num;
	logic [ahd_pkg::LEVEL_W-1:0]   inc;
	logic [17:0]                   att_sum;
	logic [ahd_pkg::LEVEL_W-1:0]   upd_level;
	ahd_pkg::phase_t               upd_phase;
	logic [15:0]                   span;
	logic [15:0]                   shaped;
	logic                          out_load;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign in_fire   = (s_tuser == ahd_pkg::OP_FIRE);
	assign in_finger = s_tdata[0];

	// finger lift in hold mode cuts attack or hold into decay
	always_comb begin
		ph_mid = phase_q;
		if (hold_mode_q && !in_finger &&
		    (phase_q == ahd_pkg::PH_ATTACK || phase_q == ahd_pkg::PH_HOLD)) begin
			ph_mid = ahd_pkg::PH_DECAY;
		end
	end

	// division numerator from the clamped stage step
	always_comb begin
		step_sel     = (ph_mid == ahd_pkg::PH_ATTACK) ? attack_step_q : decay_step_q;
		step_clamped = (step_sel > STEP_MAX) ? STEP_MAX : step_sel;
		div_num      = ahd_pkg::DIV_NUM >> step_clamped;
	end

	// increment: full scale for very short stages, at least one
	always_comb begin
		if (|unit_sts.quo[ahd_pkg::DIV_NUM_W-1:16]) begin
			inc = ahd_pkg::FULL_SCALE;
		end else if (unit_sts.quo == '0) begin
			inc = ahd_pkg::LEVEL_W'(1);
		end else begin
			inc = unit_sts.quo[ahd_pkg::LEVEL_W-1:0];
		end
	end

	// attack and decay level update
	always_comb begin
		att_sum   = {1'b0, level_q} + {1'b0, inc};
		upd_level = level_q;
		upd_phase = phase_q;
		if (phase_q == ahd_pkg::PH_ATTACK) begin
			if (att_sum >= {1'b0, ahd_pkg::FULL_SCALE}) begin
				upd_level = ahd_pkg::FULL_SCALE;
				upd_phase = (hold_mode_q && finger_q) ? ahd_pkg::PH_HOLD : ahd_pkg::PH_DECAY;
			end else begin
				upd_level = att_sum[ahd_pkg::LEVEL_W-1:0];
			end
		end else if (inc >= level_q) begin
			upd_level = '0;
			upd_phase = ahd_pkg::PH_IDLE;
		end else begin
			upd_level = level_q - inc;
		end
	end

	// shaped value from the product
	assign span     = ceiling_value_q - base_value_q;
	assign shaped   = (ceiling_value_q <= base_value_q) ? base_value_q
	                                                   : base_value_q + unit_sts.prod;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// sequencer and envelope state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			level_q      <= '0;
			phase_q      <= ahd_pkg::PH_IDLE;
			unit_start_q <= 1'b0;
		end else begin
			unit_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unit_start_q <= 1'b1;
						if (in_fire) begin
							phase_q <= ahd_pkg::PH_ATTACK;
							state_q <= ST_MUL;
						end else if (ticks_per_bar_q == '0) begin
							state_q <= ST_MUL;
						end else begin
							phase_q <= ph_mid;
							case (ph_mid)
								ahd_pkg::PH_ATTACK, ahd_pkg::PH_DECAY: begin
									state_q <= ST_DIV;
								end
								ahd_pkg::PH_HOLD: begin
									level_q <= ahd_pkg::FULL_SCALE;
									state_q <= ST_MUL;
								end
								default: begin
									level_q <= '0;
									state_q <= ST_MUL;
								end
							endcase
						end
					end
				end
				ST_DIV: begin
					if (unit_sts.done) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					level_q      <= upd_level;
					phase_q      <= upd_phase;
					unit_start_q <= 1'b1;
					state_q      <= ST_MUL;
				end
				ST_MUL: begin
					if (unit_sts.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// unit operands, loaded with the start pulse
	always_ff @(posedge clk) begin
		if (accept) begin
			finger_q <= in_finger;
			if (!in_fire && ticks_per_bar_q != '0 &&
			    (ph_mid == ahd_pkg::PH_ATTACK || ph_mid == ahd_pkg::PH_DECAY)) begin
				unit_mul_q <= 1'b0;
				unit_a_q   <= div_num;
				unit_b_q   <= ticks_per_bar_q;
			end else begin
				unit_mul_q <= 1'b1;
				unit_b_q   <= span;
				if (in_fire || ticks_per_bar_q == '0) begin
					unit_a_q <= {4'd0, level_q};
				end else if (ph_mid == ahd_pkg::PH_HOLD) begin
					unit_a_q <= {4'd0, ahd_pkg::FULL_SCALE};
				end else begin
					unit_a_q <= '0;
				end
			end
		end else if (state_q == ST_UPD) begin
			unit_mul_q <= 1'b1;
			unit_a_q   <= {4'd0, upd_level};
			unit_b_q   <= span;
		end
	end

	assign unit_cmd.start  = unit_start_q;
	assign unit_cmd.op_mul = unit_mul_q;
	assign unit_cmd.a      = unit_a_q;
	assign unit_cmd.b      = unit_b_q;

	ahd_iter_unit u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (unit_cmd),
		.sts    (unit_sts)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_mode_q     <= 1'b0;
			attack_step_q   <= '0;
			decay_step_q    <= '0;
			ticks_per_bar_q <= ahd_pkg::TICKS_PER_BAR_RST;
			base_value_q    <= '0;
			ceiling_value_q <= ahd_pkg::CEILING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ahd_pkg::REG_HOLD_MODE:     hold_mode_q     <= cfg_wdata[0];
				ahd_pkg::REG_ATTACK_STEP:   attack_step_q   <= cfg_wdata[ahd_pkg::STEP_W-1:0];
				ahd_pkg::REG_DECAY_STEP:    decay_step_q    <= cfg_wdata[ahd_pkg::STEP_W-1:0];
				ahd_pkg::REG_TICKS_PER_BAR: ticks_per_bar_q <= cfg_wdata;
				ahd_pkg::REG_BASE_VALUE:    base_value_q    <= cfg_wdata;
				ahd_pkg::REG_CEILING_VALUE: ceiling_value_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_level_q  <= level_q;
			out_phase_q  <= phase_q;
			out_shaped_q <= shaped;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, out_shaped_q, out_phase_q, out_level_q};

	// checks
	a_idle_unit_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !unit_sts.busy)
		else $error("shared unit busy while sequencer idle");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= ahd_pkg::FULL_SCALE)
		else $error("envelope level above full scale");

	a_idle_level_zero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == ahd_pkg::PH_IDLE |-> level_q == '0)
		else $error("idle phase with nonzero level");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_OUT))
		else $error("result word raised outside output state");

endmodule
